/* src/fdsu_pkg.sv */
// fdsu_pkg: constants, operation codes and control structs of the Forth
// data-stack unit. No dependencies; imported by every other file.
`default_nettype none

package fdsu_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CELL_W      = 32;
    localparam int KIND_W      = 4;
    localparam int PRINT_W     = 2;
    localparam int ERR_W       = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH = 4'd0;
    localparam logic [KIND_W-1:0] KIND_CR   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DROP = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DUP  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DOT  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_EMIT = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SWAP = 4'd6;
    localparam logic [KIND_W-1:0] KIND_OVER = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ROT  = 4'd8;

    localparam logic [PRINT_W-1:0] PRINT_NONE = 2'd0;
    localparam logic [PRINT_W-1:0] PRINT_NUM  = 2'd1;
    localparam logic [PRINT_W-1:0] PRINT_CHAR = 2'd2;
    localparam logic [PRINT_W-1:0] PRINT_NL   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic exec;      // run the operation, load the result register
        logic fill;      // refill the third cached cell from memory
    } fdsu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pop_op;    // pending operation removes a cell and succeeds
    } fdsu_stat_t;

endpackage

`default_nettype wire

/* src/fdsu_in_if.sv */
// fdsu_in_if: operation channel (valid/ready plus kind and push value).
// Depends on fdsu_pkg.
`default_nettype none

interface fdsu_in_if
    import fdsu_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [CELL_W-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

`default_nettype wire

/* src/fdsu_out_if.sv */
// fdsu_out_if: result channel (valid/ready plus print, error and depth).
// Depends on fdsu_pkg.
`default_nettype none

interface fdsu_out_if
    import fdsu_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [PRINT_W-1:0]       print_kind;
    logic signed [CELL_W-1:0] print_value;
    logic [ERR_W-1:0]         error_code;
    logic [DEPTH_W-1:0]       stack_depth;

    modport source (output valid, output print_kind, output print_value,
                    output error_code, output stack_depth, input ready);
    modport sink   (input valid, input print_kind, input print_value,
                    input error_code, input stack_depth, output ready);
endinterface

`default_nettype wire

/* src/fdsu_ctrl.sv */
// fdsu_ctrl: sequencing state machine of the data-stack unit; owns the
// handshakes. Depends on fdsu_pkg.
`default_nettype none

module fdsu_ctrl
    import fdsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire fdsu_stat_t stat,
    output fdsu_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       exec_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // result register is free when empty or being drained this cycle
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.capture = in_valid && in_ready;
        cmd.exec    = exec_fire;
        cmd.fill    = (state_reg == ST_FILL);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                    state_next = stat.pop_op ? ST_FILL : ST_IDLE;
            end
            ST_FILL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/fdsu_datapath.sv */
// fdsu_datapath: top three cells in registers, deeper cells in a memory,
// depth counter and result register. Depends on fdsu_pkg.
`default_nettype none

module fdsu_datapath
    import fdsu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire fdsu_cmd_t                cmd,
    output fdsu_stat_t                    stat,
    input  wire logic [KIND_W-1:0]        kind,
    input  wire logic signed [CELL_W-1:0] push_value,
    output logic [PRINT_W-1:0]            print_kind,
    output logic signed [CELL_W-1:0]      print_value,
    output logic [ERR_W-1:0]              error_code,
    output logic [DEPTH_W-1:0]            stack_depth
);

    localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

    logic [KIND_W-1:0]  kind_reg;
    logic [CELL_W-1:0]  value_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    // top0 is the top of stack; cells below the third live in mem
    logic [CELL_W-1:0]  top0_reg, top0_next;
    logic [CELL_W-1:0]  top1_reg, top1_next;
    logic [CELL_W-1:0]  top2_reg, top2_next;
    logic [CELL_W-1:0]  rd_data_reg;
    logic [CELL_W-1:0]  mem [STACK_DEPTH];

    logic [PRINT_W-1:0] print_kind_reg, print_kind_next;
    logic [CELL_W-1:0]  print_value_reg, print_value_next;
    logic [ERR_W-1:0]   error_reg, error_next;

    logic [1:0]         need;
    logic               grow;
    logic               shrink;
    logic               known;
    logic               ok;
    logic [CELL_W-1:0]  shift_in;
    logic               spill;
    logic [DEPTH_W-1:0] wr_ptr;
    logic [DEPTH_W-1:0] rd_ptr;

    always_comb
    begin
        need   = 2'd0;
        grow   = 1'b0;
        shrink = 1'b0;
        known  = 1'b1;
        unique case (kind_reg) inside
            KIND_PUSH: grow = 1'b1;
            KIND_CR:   need = 2'd0;
            KIND_DROP, KIND_DOT, KIND_EMIT:
            begin
                need   = 2'd1;
                shrink = 1'b1;
            end
            KIND_DUP:
            begin
                need = 2'd1;
                grow = 1'b1;
            end
            KIND_SWAP: need = 2'd2;
            KIND_OVER:
            begin
                need = 2'd2;
                grow = 1'b1;
            end
            KIND_ROT:  need = 2'd3;
            default:   known = 1'b0;
        endcase
    end

    always_comb
    begin
        error_next = ERR_OK;
        if (known && (depth_reg < DEPTH_W'(need)))
            error_next = ERR_UNDER;
        else if (known && grow && (depth_reg >= FULL_DEPTH))
            error_next = ERR_OVER;
    end

    assign ok          = known && (error_next == ERR_OK);
    assign stat.pop_op = ok && shrink;

    always_comb
    begin
        case (kind_reg)
            KIND_DUP:  shift_in = top0_reg;
            KIND_OVER: shift_in = top1_reg;
            default:   shift_in = value_reg;
        endcase
    end

    // spill the third cell on a push, dup or over once three cells are cached
    assign wr_ptr = depth_reg - DEPTH_W'(3);
    assign rd_ptr = depth_reg - DEPTH_W'(4);
    assign spill  = cmd.exec && ok && grow && (depth_reg >= DEPTH_W'(3));

    always_comb
    begin
        depth_next       = depth_reg;
        top0_next        = top0_reg;
        top1_next        = top1_reg;
        top2_next        = top2_reg;
        print_kind_next  = print_kind_reg;
        print_value_next = print_value_reg;
        if (cmd.fill)
            top2_next = rd_data_reg;
        if (cmd.exec)
        begin
            print_kind_next  = PRINT_NONE;
            print_value_next = '0;
            if (ok)
            begin
                case (kind_reg) inside
                    KIND_PUSH, KIND_DUP, KIND_OVER:
                    begin
                        top0_next  = shift_in;
                        top1_next  = top0_reg;
                        top2_next  = top1_reg;
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                    KIND_CR:   print_kind_next = PRINT_NL;
                    KIND_DROP, KIND_DOT, KIND_EMIT:
                    begin
                        top0_next  = top1_reg;
                        top1_next  = top2_reg;
                        depth_next = depth_reg - DEPTH_W'(1);
                        if (kind_reg == KIND_DOT)
                        begin
                            print_kind_next  = PRINT_NUM;
                            print_value_next = top0_reg;
                        end
                        else if (kind_reg == KIND_EMIT)
                        begin
                            print_kind_next  = PRINT_CHAR;
                            print_value_next = {{(CELL_W-8){1'b0}}, top0_reg[7:0]};
                        end
                    end
                    KIND_SWAP:
                    begin
                        top0_next = top1_reg;
                        top1_next = top0_reg;
                    end
                    KIND_ROT:
                    begin
                        top0_next = top2_reg;
                        top1_next = top0_reg;
                        top2_next = top1_reg;
                    end
                    default:
                    begin
                        top0_next = top0_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else
            depth_reg <= depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            value_reg <= push_value;
        end
        if (cmd.exec)
            error_reg <= error_next;
        top0_reg        <= top0_next;
        top1_reg        <= top1_next;
        top2_reg        <= top2_next;
        print_kind_reg  <= print_kind_next;
        print_value_reg <= print_value_next;
    end

    // spill/refill memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (spill)
            mem[wr_ptr[ADDR_W-1:0]] <= top2_reg;
        rd_data_reg <= mem[rd_ptr[ADDR_W-1:0]];
    end

    assign print_kind  = print_kind_reg;
    assign print_value = print_value_reg;
    assign error_code  = error_reg;
    assign stack_depth = depth_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= FULL_DEPTH)
        else $error("stack depth beyond capacity");

    a_error_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (error_next != ERR_OK) |=> depth_reg == $past(depth_reg))
        else $error("failed operation changed the depth");

    a_grow_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && ok && grow |=> depth_reg == $past(depth_reg) + DEPTH_W'(1))
        else $error("successful push did not add one cell");

    a_fill_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> $past(cmd.exec) && $past(stat.pop_op))
        else $error("refill without a preceding pop");

endmodule

`default_nettype wire

/* src/forth_data_stack_unit_core.sv */
// Forth data-stack unit: one result per operation, print/error/depth.
// Each operation is captured on transfer, then executed once the result
// register is free (a result not yet taken holds off execution); the
// result is registered. A new operation is taken only after execution
// and, for a successful drop, dot or emit, the refill of the third cached
// cell from the spill memory's registered read port. Reset (rst_n, async,
// active low): stack empty, no result pending; memory cells not cleared.
`default_nettype none

module forth_data_stack_unit_core
    import fdsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fdsu_in_if.sink   cmd,
    fdsu_out_if.source rsp
);

    fdsu_cmd_t  ctl_cmd;
    fdsu_stat_t ctl_stat;

    fdsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (ctl_stat),
        .cmd       (ctl_cmd)
    );

    fdsu_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .stat        (ctl_stat),
        .kind        (cmd.kind),
        .push_value  (cmd.push_value),
        .print_kind  (rsp.print_kind),
        .print_value (rsp.print_value),
        .error_code  (rsp.error_code),
        .stack_depth (rsp.stack_depth)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for forth_data_stack_unit_core: an operation stream and a result stream
// checked against a cycle-free stack predictor held in a small scoreboard class.
// Depends on fdsu_pkg, fdsu_in_if, fdsu_out_if and the core RTL.
`timescale 1ns / 1ps

module testbench
    import fdsu_pkg::*;
;

    typedef struct packed {
        logic [PRINT_W-1:0]       print_kind;
        logic signed [CELL_W-1:0] print_value;
        logic [ERR_W-1:0]         error_code;
        logic [DEPTH_W-1:0]       stack_depth;
    } stack_result_t;

    class stack_tracker;
        logic [CELL_W-1:0] cells [STACK_DEPTH];
        int unsigned       depth;
        stack_result_t     pending_results [$];
        int unsigned       failures;

        function new();
            depth    = 0;
            failures = 0;
        endfunction

        // Apply one accepted operation and queue the result it should produce.
        function void note_op(logic [KIND_W-1:0] k, logic [CELL_W-1:0] v);
            stack_result_t     r;
            int unsigned       need;
            bit                grows;
            bit                known;
            logic [CELL_W-1:0] a;
            logic [CELL_W-1:0] b;
            logic [CELL_W-1:0] c;
            r.print_kind  = PRINT_NONE;
            r.print_value = '0;
            r.error_code  = ERR_OK;
            need  = 0;
            grows = 1'b0;
            known = 1'b1;
            case (k) inside
                KIND_PUSH: grows = 1'b1;
                KIND_CR: ;
                KIND_DROP, KIND_DOT, KIND_EMIT: need = 1;
                KIND_DUP:
                begin
                    need  = 1;
                    grows = 1'b1;
                end
                KIND_SWAP: need = 2;
                KIND_OVER:
                begin
                    need  = 2;
                    grows = 1'b1;
                end
                KIND_ROT: need = 3;
                default: known = 1'b0;
            endcase
            // underflow takes precedence over overflow
            if (known && depth < need)
                r.error_code = ERR_UNDER;
            else if (known && grows && depth >= STACK_DEPTH)
                r.error_code = ERR_OVER;
            if (known && r.error_code == ERR_OK)
            begin
                case (k)
                    KIND_PUSH:
                    begin
                        cells[depth] = v;
                        depth++;
                    end
                    KIND_CR: r.print_kind = PRINT_NL;
                    KIND_DROP: depth--;
                    KIND_DUP:
                    begin
                        cells[depth] = cells[depth-1];
                        depth++;
                    end
                    KIND_DOT:
                    begin
                        r.print_kind  = PRINT_NUM;
                        r.print_value = cells[depth-1];
                        depth--;
                    end
                    KIND_EMIT:
                    begin
                        r.print_kind  = PRINT_CHAR;
                        r.print_value = {{(CELL_W-8){1'b0}}, cells[depth-1][7:0]};
                        depth--;
                    end
                    KIND_SWAP:
                    begin
                        a = cells[depth-1];
                        cells[depth-1] = cells[depth-2];
                        cells[depth-2] = a;
                    end
                    KIND_OVER:
                    begin
                        cells[depth] = cells[depth-2];
                        depth++;
                    end
                    KIND_ROT:
                    begin
                        // ( a b c -- b c a )
                        c = cells[depth-1];
                        b = cells[depth-2];
                        a = cells[depth-3];
                        cells[depth-3] = b;
                        cells[depth-2] = c;
                        cells[depth-1] = a;
                    end
                    default: ;
                endcase
            end
            r.stack_depth = DEPTH_W'(depth);
            pending_results.push_back(r);
        endfunction

        function void check_result(stack_result_t got);
            stack_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: kind %0d value %0d",
                       got.print_kind, got.print_value);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.print_kind !== want.print_kind)
            begin
                $error("print_kind: expected %0d, actual %0d", want.print_kind, got.print_kind);
                failures++;
            end
            if (got.print_value !== want.print_value)
            begin
                $error("print_value: expected %0d, actual %0d",
                       want.print_value, got.print_value);
                failures++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
                failures++;
            end
            if (got.stack_depth !== want.stack_depth)
            begin
                $error("stack_depth: expected %0d, actual %0d",
                       want.stack_depth, got.stack_depth);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    bit   filling;

    stack_tracker tracker = new();

    fdsu_in_if  cmd_ch ();
    fdsu_out_if rsp_ch ();

    forth_data_stack_unit_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Both transfers are observed here, with values as they stood at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                tracker.note_op(cmd_ch.kind, cmd_ch.push_value);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result({rsp_ch.print_kind, rsp_ch.print_value,
                                      rsp_ch.error_code, rsp_ch.stack_depth});
        end
    end

    task automatic send_op(input logic [KIND_W-1:0] k, input logic [CELL_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= k;
        cmd_ch.push_value <= v;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CELL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom;
        else if (r < 80)
            return CELL_W'($urandom_range(0, 300));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(CELL_W-1){1'b0}}};
            default: return {1'b0, {(CELL_W-1){1'b1}}};
        endcase
    endfunction

    // Drift the stack between empty and full so both error edges are hit often.
    task automatic send_random_op();
        int unsigned         r;
        logic [KIND_W-1:0]   k;
        if (tracker.depth >= STACK_DEPTH && $urandom_range(0, 2) == 0)
            filling = 1'b0;
        else if (tracker.depth == 0 && $urandom_range(0, 2) == 0)
            filling = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 3)
            k = KIND_W'($urandom_range(int'(KIND_ROT) + 1, (1 << KIND_W) - 1));
        else if (r < 8)
            k = KIND_CR;
        else if (filling)
        begin
            if (r < 50)      k = KIND_PUSH;
            else if (r < 62) k = KIND_DUP;
            else if (r < 72) k = KIND_OVER;
            else if (r < 80) k = KIND_SWAP;
            else if (r < 88) k = KIND_ROT;
            else if (r < 92) k = KIND_DROP;
            else if (r < 96) k = KIND_DOT;
            else             k = KIND_EMIT;
        end
        else
        begin
            if (r < 20)      k = KIND_PUSH;
            else if (r < 26) k = KIND_DUP;
            else if (r < 30) k = KIND_OVER;
            else if (r < 38) k = KIND_SWAP;
            else if (r < 45) k = KIND_ROT;
            else if (r < 65) k = KIND_DROP;
            else if (r < 82) k = KIND_DOT;
            else             k = KIND_EMIT;
        end
        // push_value is ignored off push but still toggled
        send_op(k, pick_value());
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.kind       <= KIND_CR;
        cmd_ch.push_value <= '0;
        send_idle = 38;
        recv_idle = 70;
        filling   = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // underflow on empty stack, cr, unused kinds
        send_op(KIND_DROP, '0);
        send_op(KIND_DOT,  '0);
        send_op(KIND_EMIT, '0);
        send_op(KIND_SWAP, '0);
        send_op(KIND_OVER, '0);
        send_op(KIND_ROT,  '0);
        send_op(KIND_DUP,  '0);
        send_op(KIND_CR,   '0);
        send_op(KIND_W'(int'(KIND_ROT) + 1), '1);
        send_op('1, '1);
        // value extremes and stack shuffles
        send_op(KIND_PUSH, {1'b0, {(CELL_W-1){1'b1}}});
        send_op(KIND_PUSH, {1'b1, {(CELL_W-1){1'b0}}});
        send_op(KIND_SWAP, '0);
        send_op(KIND_ROT,  '0);
        send_op(KIND_PUSH, '1);
        send_op(KIND_ROT,  '0);
        send_op(KIND_OVER, '0);
        send_op(KIND_DUP,  '0);
        send_op(KIND_DOT,  '0);
        send_op(KIND_EMIT, '0);
        send_op(KIND_EMIT, '0);
        send_op(KIND_DOT,  '0);
        send_op(KIND_DROP, '0);
        send_op(KIND_PUSH, '0);
        send_op(KIND_DOT,  '0);
        wait_results_drained();

        repeat (200) send_random_op();
        wait_results_drained();
        send_idle = 70;
        recv_idle = 38;
        repeat (200) send_random_op();
        send_idle = 0;
        recv_idle = 0;
        repeat (200) send_random_op();
        wait_results_drained();

        repeat (8) @(posedge clk);
        if (tracker.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* forth_data_stack_unit_core.f */
src/fdsu_pkg.sv
src/fdsu_in_if.sv
src/fdsu_out_if.sv
src/fdsu_ctrl.sv
src/fdsu_datapath.sv
src/forth_data_stack_unit_core.sv
dv/testbench.sv
